FILE: hdl/gha_pkg.sv
package gha_pkg;

  // Fixed handle layout: generation above index in one 64-bit word
  localparam int unsigned HandleBits = 64;
  localparam int unsigned GenBits    = 32;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EVAL
  } state_e;

  typedef struct packed {
    opcode_e                opcode;
    logic [HandleBits-1:0]  handle;
  } cmd_t;

  typedef struct packed {
    logic [HandleBits-1:0]  new_handle;
    logic                   ok;
    status_e                status;
  } result_t;

endpackage

FILE: hdl/generational_handle_allocator_top.sv
// Allocate of a fresh slot, pool-full and out-of-range/invalid handles answer with done_o
// in the cycle after the accept; free and check read slot memory, then compare (free also
// writes back); allocate from the free stack reads the stack, then the slot, then writes.
// busy is high outside S_IDLE, so a new word is taken only once the last one is through.
// Reset clears control state only; memories are not swept since the used-slot count marks
// which entries hold data. The receiver cannot stall; each result shows for one cycle.
module generational_handle_allocator_top #(
  parameter int unsigned SLOT_COUNT       = 1024,
  parameter int unsigned INDEX_FIELD_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  gha_pkg::cmd_t    cmd_i,
  output logic             busy,
  output gha_pkg::result_t result_o,
  output logic             done_o
);
  import gha_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned GenW = HandleBits - INDEX_FIELD_BITS;
  localparam int unsigned EntW = GenBits + 1;

  // Slot generation as it appears in a handle's generation field
  function automatic logic [GenW-1:0] gen_field(input logic [GenBits-1:0] g);
    logic [GenW+GenBits-1:0] wide;
    wide = {{GenW{1'b0}}, g};
    return wide[GenW-1:0];
  endfunction

  state_e                  state_q, state_d;
  opcode_e                 op_q, op_d;
  logic [GenW-1:0]         gen_in_q, gen_in_d;
  logic [IdxW-1:0]         slot_q, slot_d;
  logic [CntW-1:0]         free_count_q, free_count_d;
  logic [CntW-1:0]         used_q, used_d;
  result_t                 result_q, result_d;
  logic                    done_q, done_d;

  // Slot memory: {live, generation}
  logic [EntW-1:0]         slot_mem [SLOT_COUNT];
  logic                    slot_rd_en, slot_wr_en;
  logic [IdxW-1:0]         slot_rd_addr, slot_wr_addr;
  logic [EntW-1:0]         slot_wr_data, slot_rd_q;

  // Free stack memory
  logic [IdxW-1:0]         stack_mem [SLOT_COUNT];
  logic                    stack_rd_en, stack_wr_en;
  logic [IdxW-1:0]         stack_rd_addr, stack_wr_addr, stack_rd_q;

  // Incoming handle decode
  logic [INDEX_FIELD_BITS-1:0] idx_full;
  logic [IdxW-1:0]             idx_lo;
  logic                        in_range, quick_bad;
  logic [CntW-1:0]             fc_dec;

  // Read-back decode
  logic                    ent_live, gen_match, free_room;
  logic [GenBits-1:0]      ent_gen;

  assign idx_full  = cmd_i.handle[INDEX_FIELD_BITS-1:0];
  assign idx_lo    = idx_full[IdxW-1:0];
  assign in_range  = ((idx_full >> IdxW) == '0) && (CntW'(idx_lo) < used_q);
  assign quick_bad = (cmd_i.handle == '1) || !in_range;
  assign fc_dec    = free_count_q - 1'b1;

  assign ent_live  = slot_rd_q[GenBits];
  assign ent_gen   = slot_rd_q[GenBits-1:0];
  assign gen_match = ent_live && (gen_in_q == gen_field(ent_gen));
  assign free_room = free_count_q < CntW'(SLOT_COUNT);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (cmd_i.opcode == OP_ALLOC) begin
            if (free_count_q != '0) state_d = S_POP;
          end else if (!quick_bad) begin
            state_d = S_EVAL;
          end
        end
      end
      S_POP:   state_d = S_EVAL;
      S_EVAL:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result
  always_comb begin
    op_d          = op_q;
    gen_in_d      = gen_in_q;
    slot_d        = slot_q;
    free_count_d  = free_count_q;
    used_d        = used_q;
    result_d      = result_q;
    done_d        = 1'b0;
    slot_rd_en    = 1'b0;
    slot_rd_addr  = idx_lo;
    slot_wr_en    = 1'b0;
    slot_wr_addr  = slot_q;
    slot_wr_data  = slot_rd_q;
    stack_rd_en   = 1'b0;
    stack_rd_addr = fc_dec[IdxW-1:0];
    stack_wr_en   = 1'b0;
    stack_wr_addr = free_count_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = cmd_i.opcode;
          gen_in_d = cmd_i.handle[HandleBits-1:INDEX_FIELD_BITS];
          slot_d   = idx_lo;
          if (cmd_i.opcode == OP_ALLOC) begin
            if (free_count_q != '0) begin
              // pop: read top of stack
              stack_rd_en  = 1'b1;
              free_count_d = fc_dec;
            end else if (used_q < CntW'(SLOT_COUNT)) begin
              // fresh slot: generation zero, no read needed
              slot_wr_en   = 1'b1;
              slot_wr_addr = used_q[IdxW-1:0];
              slot_wr_data = {1'b1, {GenBits{1'b0}}};
              used_d       = used_q + 1'b1;
              result_d     = '{new_handle: {{GenW{1'b0}},
                                            INDEX_FIELD_BITS'(used_q[IdxW-1:0])},
                               ok: 1'b1, status: ST_OK};
              done_d       = 1'b1;
            end else begin
              result_d = '{new_handle: '1, ok: 1'b0, status: ST_FULL};
              done_d   = 1'b1;
            end
          end else if (quick_bad) begin
            result_d = '{new_handle: '1, ok: 1'b0, status: ST_BAD};
            done_d   = 1'b1;
          end else begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = idx_lo;
          end
        end
      end

      S_POP: begin
        slot_rd_en   = 1'b1;
        slot_rd_addr = stack_rd_q;
        slot_d       = stack_rd_q;
      end

      S_EVAL: begin
        done_d = 1'b1;
        case (op_q)
          OP_ALLOC: begin
            slot_wr_en   = 1'b1;
            slot_wr_data = {1'b1, ent_gen};
            result_d     = '{new_handle: {gen_field(ent_gen), INDEX_FIELD_BITS'(slot_q)},
                             ok: 1'b1, status: ST_OK};
          end
          OP_FREE: begin
            if (gen_match && free_room) begin
              slot_wr_en   = 1'b1;
              slot_wr_data = {1'b0, ent_gen + 1'b1};
              stack_wr_en  = 1'b1;
              free_count_d = free_count_q + 1'b1;
              result_d     = '{new_handle: '1, ok: 1'b1, status: ST_OK};
            end else begin
              result_d = '{new_handle: '1, ok: 1'b0, status: ST_BAD};
            end
          end
          default: begin
            // check, and the unused opcode
            if (gen_match) result_d = '{new_handle: '1, ok: 1'b1, status: ST_OK};
            else           result_d = '{new_handle: '1, ok: 1'b0, status: ST_BAD};
          end
        endcase
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_count_q <= '0;
      used_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_count_q <= free_count_d;
      used_q       <= used_d;
      done_q       <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    gen_in_q <= gen_in_d;
    slot_q   <= slot_d;
    result_q <= result_d;
  end

  // Slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (slot_wr_en) slot_mem[slot_wr_addr] <= slot_wr_data;
    if (slot_rd_en) slot_rd_q <= slot_mem[slot_rd_addr];
  end

  // Free stack memory
  always_ff @(posedge clk_i) begin
    if (stack_wr_en) stack_mem[stack_wr_addr] <= slot_q;
    if (stack_rd_en) stack_rd_q <= stack_mem[stack_rd_addr];
  end

  assign busy     = (state_q != S_IDLE);
  assign result_o = result_q;
  assign done_o   = done_q;

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import gha_pkg::*;

  localparam int unsigned SlotCount = 1024;
  localparam int unsigned IndexBits = 32;
  // Opcode three has no package name; the block treats it as a check
  localparam logic [1:0] OpReserved = 2'd3;
  localparam logic [63:0] NoHandle = '1;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  cmd_t    cmd_i;
  logic    busy;
  result_t result_o;
  logic    done_o;

  generational_handle_allocator_top #(
    .SLOT_COUNT      (SlotCount),
    .INDEX_FIELD_BITS(IndexBits)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .cmd_i   (cmd_i),
    .busy    (busy),
    .result_o(result_o),
    .done_o  (done_o)
  );

  // Predicted allocator state
  bit [31:0]   gen_mem [SlotCount];
  bit          live_mem [SlotCount];
  int unsigned freed_stack [SlotCount];
  int unsigned freed_depth;
  int unsigned slots_issued;

  result_t     awaited_results [$];
  result_t     want_result;
  int unsigned error_count;
  int unsigned results_checked;
  int unsigned cmds_sent;
  int unsigned full_rejects;
  bit          burst_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
    error_count++;
  endtask

  // Handle validity against the predicted slot table
  function automatic bit handle_current(input logic [63:0] h, output int unsigned slot);
    logic [63:0] idx;
    logic [63:0] gen_fld;
    slot = 0;
    if (h == NoHandle) return 1'b0;
    idx = h & ((64'd1 << IndexBits) - 64'd1);
    if (idx >= 64'(slots_issued) || idx >= 64'(SlotCount)) return 1'b0;
    slot = int'(idx);
    gen_fld = (64'(gen_mem[slot]) << IndexBits) >> IndexBits;
    return live_mem[slot] && ((h >> IndexBits) == gen_fld);
  endfunction

  // One command applied to the predicted state; returns the expected word
  function automatic result_t allocator_predict(input cmd_t c);
    result_t     r;
    int unsigned slot;
    bit          got;
    r.new_handle = NoHandle;
    r.ok         = 1'b0;
    r.status     = ST_OK;
    got          = 1'b0;
    case (c.opcode)
      OP_ALLOC: begin
        if (freed_depth > 0) begin
          freed_depth--;
          slot = freed_stack[freed_depth];
          got  = 1'b1;
        end else if (slots_issued < SlotCount) begin
          slot = slots_issued;
          slots_issued++;
          got  = 1'b1;
        end
        if (got) begin
          live_mem[slot] = 1'b1;
          r.new_handle   = (64'(gen_mem[slot]) << IndexBits) | 64'(slot);
          r.ok           = 1'b1;
        end else begin
          r.status = ST_FULL;
          full_rejects++;
        end
      end
      OP_FREE: begin
        if (handle_current(c.handle, slot) && freed_depth < SlotCount) begin
          live_mem[slot]           = 1'b0;
          gen_mem[slot]            = gen_mem[slot] + 32'd1;
          freed_stack[freed_depth] = slot;
          freed_depth++;
          r.ok = 1'b1;
        end else begin
          r.status = ST_BAD;
        end
      end
      default: begin
        if (handle_current(c.handle, slot)) r.ok = 1'b1;
        else r.status = ST_BAD;
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [63:0] random_handle();
    return {$urandom, $urandom};
  endfunction

  // Current handle of some live slot, scanning from a random start
  function automatic bit find_live(output logic [63:0] h);
    int unsigned base;
    int unsigned idx;
    h = NoHandle;
    if (slots_issued == 0) return 1'b0;
    base = $urandom_range(0, slots_issued - 1);
    for (int unsigned k = 0; k < slots_issued; k++) begin
      idx = (base + k) % slots_issued;
      if (live_mem[idx]) begin
        h = (64'(gen_mem[idx]) << IndexBits) | 64'(idx);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Handle with an in-range index that is stale or names a dead slot
  function automatic logic [63:0] stale_handle();
    int unsigned idx;
    bit [31:0]   g;
    if (slots_issued == 0) return random_handle();
    idx = $urandom_range(0, slots_issued - 1);
    if (live_mem[idx]) g = gen_mem[idx] - 32'($urandom_range(1, 3));
    else if ($urandom_range(0, 1) == 0) g = gen_mem[idx];
    else g = gen_mem[idx] - 32'd1;
    return (64'(g) << IndexBits) | 64'(idx);
  endfunction

  // Drive one command word, wait for its accept, queue the prediction
  task automatic issue_cmd(input opcode_e op, input logic [63:0] h, output result_t exp);
    cmd_t        c;
    int unsigned gap;
    gap      = draw_gap();
    c.opcode = op;
    c.handle = h;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    exp = allocator_predict(c);
    awaited_results = {awaited_results, exp};
    cmds_sent++;
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Result checker: every done word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result word", result_o.new_handle, NoHandle);
      end else begin
        want_result = awaited_results.pop_front();
        results_checked++;
        if (result_o.new_handle !== want_result.new_handle)
          report_mismatch("new_handle", result_o.new_handle, want_result.new_handle);
        if (result_o.ok !== want_result.ok)
          report_mismatch("ok", 64'(result_o.ok), 64'(want_result.ok));
        if (result_o.status !== want_result.status)
          report_mismatch("status", 64'(result_o.status), 64'(want_result.status));
      end
    end
  end

  // Empty pool, bad handles, reuse order, reserved opcode
  task automatic test_directed();
    result_t     r;
    logic [63:0] h0;
    logic [63:0] h1;
    logic [63:0] h2;
    burst_mode = 1'b0;
    issue_cmd(OP_CHECK, 64'd0, r);
    issue_cmd(OP_CHECK, NoHandle, r);
    issue_cmd(OP_FREE, 64'd0, r);
    issue_cmd(OP_FREE, NoHandle, r);
    issue_cmd(OP_ALLOC, NoHandle, r);
    h0 = r.new_handle;
    issue_cmd(OP_CHECK, h0, r);
    issue_cmd(opcode_e'(OpReserved), h0, r);
    issue_cmd(OP_CHECK, h0 ^ (64'd1 << IndexBits), r);
    issue_cmd(OP_CHECK, {32'hFFFF_FFFF, 32'd0}, r);
    issue_cmd(OP_CHECK, {32'd0, 32'hFFFF_FFFF}, r);
    issue_cmd(OP_ALLOC, 64'd0, r);
    h1 = r.new_handle;
    // index equal to the used count, then index with high bits set
    issue_cmd(OP_CHECK, {32'd0, 32'd2}, r);
    issue_cmd(OP_CHECK, {32'd0, 32'h0001_0001}, r);
    issue_cmd(OP_FREE, h0, r);
    issue_cmd(OP_FREE, h0, r);
    issue_cmd(OP_CHECK, h0, r);
    // dead slot named with its new generation
    issue_cmd(OP_FREE, h0 + (64'd1 << IndexBits), r);
    issue_cmd(OP_ALLOC, random_handle(), r);
    h2 = r.new_handle;
    issue_cmd(OP_FREE, h1, r);
    issue_cmd(OP_FREE, h2, r);
    // last freed comes back first
    issue_cmd(OP_ALLOC, NoHandle, r);
    issue_cmd(OP_ALLOC, NoHandle, r);
    issue_cmd(opcode_e'(OpReserved), NoHandle, r);
    issue_cmd(OP_CHECK, h2, r);
  endtask

  // Mostly well-formed traffic on live handles, with stale and junk handles mixed in
  task automatic test_random_traffic();
    result_t     r;
    logic [63:0] h;
    int unsigned pick;
    for (int unsigned i = 0; i < 725; i++) begin
      if (i % 60 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if (i == 375) hold_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        issue_cmd(OP_ALLOC, random_handle(), r);
      end else if (pick < 60) begin
        if (!find_live(h)) h = random_handle();
        issue_cmd(OP_FREE, h, r);
      end else if (pick < 72) begin
        if (!find_live(h)) h = random_handle();
        issue_cmd(OP_CHECK, h, r);
      end else if (pick < 80) begin
        issue_cmd(OP_FREE, stale_handle(), r);
      end else if (pick < 86) begin
        issue_cmd(OP_CHECK, stale_handle(), r);
      end else if (pick < 94) begin
        issue_cmd((pick % 2 == 0) ? OP_FREE : OP_CHECK, random_handle(), r);
      end else if (pick < 97) begin
        if (!find_live(h) || $urandom_range(0, 1) == 0) h = random_handle();
        issue_cmd(opcode_e'(OpReserved), h, r);
      end else begin
        issue_cmd((pick % 2 == 0) ? OP_FREE : OP_CHECK, NoHandle, r);
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start  <= 1'b0;
    cmd_i  <= '0;
    error_count     = 0;
    results_checked = 0;
    cmds_sent       = 0;
    full_rejects    = 0;
    freed_depth     = 0;
    slots_issued    = 0;
    burst_mode      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    hold_until_drained();
    test_random_traffic();

    // drain, then a few idle cycles to catch stray words
    start <= 1'b0;
    for (int k = 0; k < 200 && awaited_results.size() != 0; k++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch("results never returned", 64'(awaited_results.size()), 64'd0);

    $display("Ran %0d allocate/free/check commands, %0d result words compared.",
             cmds_sent, results_checked);
    $display("%0d slots handed out; %0d allocates rejected as full.",
             slots_issued, full_rejects);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
